// ===== rtl/core/vpc_pkg.sv =====
// Shared types and constants of the vegetation pixel classifier.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package vpc_pkg;

	// Default sizing, handed to the top level's parameters.
	localparam int MAX_BANDS_DEF   = 256;
	localparam int MAX_PIXELS_DEF  = 1048576;
	localparam int SAMPLE_BITS_DEF = 16;

	// Depth of the record queue between the band scanner and the classifier.
	localparam int QUEUE_DEPTH = 2;

	// Quotient bits of the NDVI divider: one integer bit and sixteen fraction bits.
	localparam int DIV_STEPS = 17;

	localparam int CFG_DATA_W  = 17;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_NIR_BAND        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RED_BAND        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EDGE_FIRST_BAND = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EDGE_LAST_BAND  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NDVI_LIMIT      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_EDGE_LIMIT      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TEST_MODE       = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_REJECT_LABEL    = 3'd7;

	localparam logic signed [15:0] NDVI_LIMIT_RESET = 16'sd9830;
	localparam logic [1:0]         TEST_MODE_RESET  = 2'b11;
	localparam logic signed [15:0] VEG_MASK         = -16'sd1;

	typedef struct packed {
		logic        [7:0]  nir_band;
		logic        [7:0]  red_band;
		logic        [7:0]  edge_first_band;
		logic        [7:0]  edge_last_band;
		logic signed [15:0] ndvi_limit;
		logic signed [16:0] edge_limit;
		logic        [1:0]  test_mode;
		logic signed [15:0] reject_label;
	} cfg_t;

	// One finished pixel as seen by the classifier.
	typedef struct packed {
		logic [14:0] nir;
		logic [14:0] red;
		logic [15:0] step;
		logic [19:0] pixel_index;
		logic        clr_count;
	} rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/vpc_stream_if.sv =====
// Valid/ready stream interfaces for band samples and pixel results.
// Depends on vpc_pkg for the default sample width.
`default_nettype none

interface vpc_in_if #(
	parameter int SAMPLE_BITS = vpc_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_band;
	logic                          start_of_image;

	modport source(output valid, sample, last_band, start_of_image, input ready);
	modport sink(input valid, sample, last_band, start_of_image, output ready);
endinterface

interface vpc_out_if;
	logic               valid;
	logic               ready;
	logic        [19:0] pixel_index;
	logic signed [15:0] ndvi;
	logic               veg_flag;
	logic signed [15:0] mask_value;
	logic        [15:0] edge_step;
	logic        [20:0] vegetation_count;

	modport source(output valid, pixel_index, ndvi, veg_flag, mask_value, edge_step,
		vegetation_count, input ready);
	modport sink(input valid, pixel_index, ndvi, veg_flag, mask_value, edge_step,
		vegetation_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vpc_queue.sv =====
// Small register FIFO of pixel records between scanner and classifier.
// Depends on vpc_pkg for the record type.
`default_nettype none

module vpc_queue #(
	parameter int DEPTH = vpc_pkg::QUEUE_DEPTH
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  vpc_pkg::rec_t      push_rec,
	output logic               full,
	input  wire                pop,
	output logic               not_empty,
	output vpc_pkg::rec_t      head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	vpc_pkg::rec_t  entry_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vpc_front.sv =====
// Band scanner: takes one sample a cycle while the queue has room, captures NIR and
// red, tracks the red edge step and hands a record per pixel to the queue. Uses vpc_pkg.
`default_nettype none

module vpc_front #(
	parameter int MAX_BANDS   = vpc_pkg::MAX_BANDS_DEF,
	parameter int MAX_PIXELS  = vpc_pkg::MAX_PIXELS_DEF,
	parameter int SAMPLE_BITS = vpc_pkg::SAMPLE_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  vpc_pkg::cfg_t    cfg,
	vpc_in_if.sink           samples,
	input  wire              q_full,
	output logic             push,
	output vpc_pkg::rec_t    push_rec
);

	localparam int BC_W  = $clog2(MAX_BANDS + 1);
	localparam int CMP_W = (BC_W > 8) ? BC_W : 8;
	localparam int PIX_W = $clog2(MAX_PIXELS + 1);
	localparam int CW    = (SAMPLE_BITS >= 17) ? SAMPLE_BITS + 1 : 18;

	logic [BC_W-1:0]               band_q, b_cur, b_nx;
	logic [14:0]                   nir_q, nir_cur, nir_nx;
	logic [14:0]                   red_q, red_cur, red_nx;
	logic signed [SAMPLE_BITS-1:0] prev_q, prev_cur, prev_nx;
	logic [15:0]                   best_q, best_cur, best_nx;
	logic                          done_q, done_cur, done_nx;
	logic [PIX_W-1:0]              pix_q, pix_cur, pix_nx;
	logic                          clr_pend_q;

	logic                          accept;
	logic                          sof;
	logic                          range_ok;
	logic [CMP_W-1:0]              bx;
	logic signed [CW-1:0]          s_x, d;
	logic [14:0]                   clamped;

	assign samples.ready = !q_full;
	assign accept        = samples.valid && samples.ready;
	assign sof           = samples.start_of_image;
	assign range_ok      = cfg.edge_last_band > cfg.edge_first_band;

	always_comb begin
		// Start of image discards the partial pixel before this sample is used.
		b_cur    = sof ? '0 : band_q;
		nir_cur  = sof ? '0 : nir_q;
		red_cur  = sof ? '0 : red_q;
		prev_cur = sof ? '0 : prev_q;
		best_cur = sof ? '0 : best_q;
		done_cur = sof ? 1'b0 : done_q;
		pix_cur  = sof ? '0 : pix_q;

		b_nx    = b_cur;
		nir_nx  = nir_cur;
		red_nx  = red_cur;
		prev_nx = prev_cur;
		best_nx = best_cur;
		done_nx = done_cur;

		bx  = CMP_W'(b_cur);
		s_x = CW'(samples.sample);
		d   = s_x - CW'(prev_cur);

		if (s_x < 0) begin
			clamped = '0;
		end else if (s_x > CW'(32767)) begin
			clamped = 15'h7FFF;
		end else begin
			clamped = s_x[14:0];
		end

		if (b_cur < BC_W'(MAX_BANDS)) begin
			if (bx == CMP_W'(cfg.nir_band)) begin
				nir_nx = clamped;
			end
			if (bx == CMP_W'(cfg.red_band)) begin
				red_nx = clamped;
			end
			if (range_ok && bx > CMP_W'(cfg.edge_first_band)
					&& bx <= CMP_W'(cfg.edge_last_band)) begin
				// The best step is unsigned; widen it before it is compared as signed.
				if (d > signed'(CW'(best_cur)) && d > 0) begin
					best_nx = (d > CW'(65535)) ? 16'hFFFF : d[15:0];
				end
			end
			if (range_ok && bx == CMP_W'(cfg.edge_last_band)) begin
				done_nx = 1'b1;
			end
			prev_nx = samples.sample;
			b_nx    = b_cur + 1'b1;
		end

		pix_nx = (pix_cur == PIX_W'(MAX_PIXELS - 1)) ? '0 : pix_cur + 1'b1;
	end

	assign push                 = accept && samples.last_band;
	assign push_rec.nir         = nir_nx;
	assign push_rec.red         = red_nx;
	assign push_rec.step        = done_nx ? best_nx : 16'd0;
	assign push_rec.pixel_index = 20'(pix_cur);
	assign push_rec.clr_count   = clr_pend_q || sof;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q     <= '0;
			nir_q      <= '0;
			red_q      <= '0;
			prev_q     <= '0;
			best_q     <= '0;
			done_q     <= 1'b0;
			pix_q      <= '0;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			if (samples.last_band) begin
				band_q     <= '0;
				nir_q      <= '0;
				red_q      <= '0;
				prev_q     <= '0;
				best_q     <= '0;
				done_q     <= 1'b0;
				pix_q      <= pix_nx;
				clr_pend_q <= 1'b0;
			end else begin
				band_q     <= b_nx;
				nir_q      <= nir_nx;
				red_q      <= red_nx;
				prev_q     <= prev_nx;
				best_q     <= best_nx;
				done_q     <= done_nx;
				pix_q      <= pix_cur;
				clr_pend_q <= clr_pend_q || sof;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vpc_back.sv =====
// Pixel classifier: divides for NDVI one quotient bit a cycle, applies the
// enabled tests, keeps the vegetation count and drives the result register.
// Uses vpc_pkg and the result stream interface.
`default_nettype none

module vpc_back #(
	parameter int MAX_PIXELS = vpc_pkg::MAX_PIXELS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  vpc_pkg::cfg_t    cfg,
	input  wire              q_not_empty,
	input  vpc_pkg::rec_t    q_head,
	output logic             pop,
	vpc_out_if.source        results
);

	localparam int VEG_W  = $clog2(MAX_PIXELS + 1);
	localparam int STEP_W = $clog2(vpc_pkg::DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_NDVI,
		ST_DEC,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [VEG_W-1:0]    veg_cnt_q;

	vpc_pkg::rec_t       rec_q;
	logic [15:0]         den_q;
	logic [16:0]         rem_q;
	logic [16:0]         quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                neg_q;
	logic signed [15:0]  ndvi_q;

	logic [16:0]         trial;
	logic                ge;
	logic [17:0]         q_inc;
	logic [16:0]         q_round;
	logic signed [16:0]  q_signed;
	logic                range_ok;
	logic                veg;
	logic [VEG_W-1:0]    cnt_base;
	logic [VEG_W-1:0]    cnt_nx;

	assign pop = (state_q == ST_IDLE) && q_not_empty;

	// Restoring division of |nir - red| * 2^16 by nir + red; the first step
	// takes the integer bit without shifting.
	assign trial = (step_q == '0) ? rem_q : {rem_q[15:0], 1'b0};
	assign ge    = trial >= {1'b0, den_q};

	// Round half away from zero on the magnitude, then restore the sign.
	assign q_inc   = {1'b0, quo_q} + 18'd1;
	assign q_round = q_inc[17:1];
	always_comb begin
		if (neg_q) begin
			q_signed = -signed'(q_round);
		end else if (q_round > 17'd32767) begin
			q_signed = 17'sd32767;
		end else begin
			q_signed = signed'(q_round);
		end
	end

	assign range_ok = cfg.edge_last_band > cfg.edge_first_band;
	always_comb begin
		veg = 1'b1;
		if (cfg.test_mode[0] && ndvi_q < cfg.ndvi_limit) begin
			veg = 1'b0;
		end
		if (cfg.test_mode[1] && range_ok && signed'({1'b0, rec_q.step}) < cfg.edge_limit) begin
			veg = 1'b0;
		end
		cnt_base = rec_q.clr_count ? '0 : veg_cnt_q;
		cnt_nx   = (veg && cnt_base < VEG_W'(MAX_PIXELS)) ? cnt_base + 1'b1 : cnt_base;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				rec_q  <= q_head;
				den_q  <= {1'b0, q_head.nir} + {1'b0, q_head.red};
				rem_q  <= (q_head.red > q_head.nir) ? 17'(q_head.red - q_head.nir)
				                                     : 17'(q_head.nir - q_head.red);
				neg_q  <= q_head.red > q_head.nir;
				quo_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= ge ? trial - {1'b0, den_q} : trial;
				quo_q  <= {quo_q[15:0], ge};
				step_q <= step_q + 1'b1;
			end
			ST_NDVI: begin
				ndvi_q <= (den_q == '0) ? 16'sd0 : q_signed[15:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q                  <= ST_IDLE;
			veg_cnt_q                <= '0;
			results.valid            <= 1'b0;
			results.pixel_index      <= '0;
			results.ndvi             <= '0;
			results.veg_flag         <= 1'b0;
			results.mask_value       <= '0;
			results.edge_step        <= '0;
			results.vegetation_count <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_not_empty) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(vpc_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_NDVI;
					end
				end
				ST_NDVI: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					veg_cnt_q                <= cnt_nx;
					results.valid            <= 1'b1;
					results.pixel_index      <= rec_q.pixel_index;
					results.ndvi             <= ndvi_q;
					results.veg_flag         <= veg;
					results.mask_value       <= veg ? vpc_pkg::VEG_MASK : cfg.reject_label;
					results.edge_step        <= rec_q.step;
					results.vegetation_count <= 21'(cnt_nx);
					state_q                  <= ST_OUT;
				end
				ST_OUT: begin
					if (results.ready) begin
						results.valid <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/vegetation_pixel_classifier.sv =====
// Top level of the vegetation pixel classifier: configuration registers,
// band scanner, record queue and classifier. Uses vpc_pkg and vpc_stream_if.
//
// The block reads a hyperspectral stream one band sample per transfer, band 0
// first, with last_band closing each pixel, and answers every pixel with one
// result transfer carrying NDVI in Q1.15, the vegetation decision, the mask
// value, the red edge step, the pixel index and the running vegetation count.
// Samples are taken at one per cycle whenever the record queue has a free slot;
// while the queue is full the scanner holds off every sample, not only the last
// band of a pixel. Each pixel then passes through the classifier's states, set by the
// 17-step bit-serial NDVI divider: loading a record, 17 division steps, rounding,
// classifying into the result register and offering the result until it is taken.
// A stream whose pixels have at least 21 bands and whose results are taken at once
// therefore flows at one sample per cycle; shorter pixels are paced by the divider,
// with two finished pixels buffered in the queue. Configuration registers are
// written through cfg_we, cfg_index and cfg_wdata and must only change while the
// block is idle.
`default_nettype none

module vegetation_pixel_classifier #(
	parameter int MAX_BANDS   = vpc_pkg::MAX_BANDS_DEF,
	parameter int MAX_PIXELS  = vpc_pkg::MAX_PIXELS_DEF,
	parameter int SAMPLE_BITS = vpc_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [vpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [vpc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	vpc_in_if.sink                             samples,
	vpc_out_if.source                          results
);

	vpc_pkg::cfg_t cfg_q;

	vpc_pkg::rec_t push_rec;
	vpc_pkg::rec_t q_head;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_not_empty;

	// Register file: each write lands in one field, narrower fields keep
	// the low bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nir_band        <= '0;
			cfg_q.red_band        <= '0;
			cfg_q.edge_first_band <= '0;
			cfg_q.edge_last_band  <= '0;
			cfg_q.ndvi_limit      <= vpc_pkg::NDVI_LIMIT_RESET;
			cfg_q.edge_limit      <= '0;
			cfg_q.test_mode       <= vpc_pkg::TEST_MODE_RESET;
			cfg_q.reject_label    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				vpc_pkg::REG_NIR_BAND:        cfg_q.nir_band        <= cfg_wdata[7:0];
				vpc_pkg::REG_RED_BAND:        cfg_q.red_band        <= cfg_wdata[7:0];
				vpc_pkg::REG_EDGE_FIRST_BAND: cfg_q.edge_first_band <= cfg_wdata[7:0];
				vpc_pkg::REG_EDGE_LAST_BAND:  cfg_q.edge_last_band  <= cfg_wdata[7:0];
				vpc_pkg::REG_NDVI_LIMIT:      cfg_q.ndvi_limit      <= signed'(cfg_wdata[15:0]);
				vpc_pkg::REG_EDGE_LIMIT:      cfg_q.edge_limit      <= signed'(cfg_wdata[16:0]);
				vpc_pkg::REG_TEST_MODE:       cfg_q.test_mode       <= cfg_wdata[1:0];
				vpc_pkg::REG_REJECT_LABEL:    cfg_q.reject_label    <= signed'(cfg_wdata[15:0]);
				default: begin
				end
			endcase
		end
	end

	// The scanner closes a pixel into a record on its last band.
	vpc_front #(
		.MAX_BANDS  (MAX_BANDS),
		.MAX_PIXELS (MAX_PIXELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.samples (samples),
		.q_full  (q_full),
		.push    (push),
		.push_rec(push_rec)
	);

	// The queue lets the scanner keep taking samples while the classifier
	// divides or waits for the result to be taken.
	vpc_queue #(
		.DEPTH(vpc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	vpc_back #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.pop        (pop),
		.results    (results)
	);

endmodule

`default_nettype wire

// ===== rtl/core/vpc_checker.sv =====
// Port-level checks of the vegetation pixel classifier's result stream,
// bound to the top level. Depends on vpc_pkg for the vegetation mask value.
`default_nettype none

module vpc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [19:0] out_pixel_index,
	input wire [15:0] out_ndvi,
	input wire        out_veg_flag,
	input wire [15:0] out_mask_value,
	input wire [20:0] out_vegetation_count
);

	// A result offered must stay offered until it is transferred.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel_index) && $stable(out_ndvi)
			&& $stable(out_vegetation_count) && $stable(out_veg_flag))
		else $error("result payload changed while stalled");

	// Vegetation pixels always carry the vegetation mask.
	a_veg_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_veg_flag |-> out_mask_value == vpc_pkg::VEG_MASK)
		else $error("vegetation pixel without vegetation mask");

	// The count includes the pixel itself, so it cannot be zero here.
	a_veg_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_veg_flag |-> out_vegetation_count != 21'd0)
		else $error("vegetation pixel with zero count");

	a_quiet_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered straight out of reset");

endmodule

bind vegetation_pixel_classifier vpc_checker u_vpc_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (results.valid),
	.out_ready           (results.ready),
	.out_pixel_index     (results.pixel_index),
	.out_ndvi            (results.ndvi),
	.out_veg_flag        (results.veg_flag),
	.out_mask_value      (results.mask_value),
	.out_vegetation_count(results.vegetation_count)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the vegetation pixel classifier: band samples in, pixel results out.
// Depends on vpc_pkg, the vpc_in_if and vpc_out_if stream interfaces and the top level itself.

module testbench;

	localparam int MAX_BANDS     = vpc_pkg::MAX_BANDS_DEF;
	localparam int MAX_PIXELS    = vpc_pkg::MAX_PIXELS_DEF;
	// A pixel occupies the classifier for a full division and two finished pixels can wait in
	// the record queue, so this many quiet cycles lets any work in flight drain out.
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ITEMS   = 125;
	localparam int PRINT_LIMIT   = 50;

	// One pixel result, laid out as the result transfer carries it.
	typedef struct packed {
		logic        [19:0] pixel_index;
		logic signed [15:0] ndvi;
		logic               veg_flag;
		logic signed [15:0] mask_value;
		logic        [15:0] edge_step;
		logic        [20:0] vegetation_count;
	} pixel_result_t;

	// Rows of the directed table: a register write, a sample whose result (if any) comes from
	// the predictor, or a closing sample whose result is typed into the table.
	typedef enum logic [1:0] {
		ROW_REG,
		ROW_SAMPLE,
		ROW_CHECKED
	} row_kind_e;

	typedef struct packed {
		row_kind_e     kind;
		logic [2:0]    reg_index;
		logic [31:0]   value;
		logic          last;
		logic          soi;
		pixel_result_t want;
	} stim_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [vpc_pkg::CFG_INDEX_W-1:0]    cfg_index;
	logic [vpc_pkg::CFG_DATA_W-1:0]     cfg_wdata;

	vpc_in_if #(.SAMPLE_BITS(16)) samples_bus ();
	vpc_out_if                    results_bus ();

	vegetation_pixel_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.samples   (samples_bus),
		.results   (results_bus)
	);

	// Expected pixel results, oldest first, and the tallies for the closing summary.
	pixel_result_t pending_results[$];
	stim_row_t     directed_rows[$];
	int            mismatches;
	int            samples_in;
	int            results_checked;
	int            veg_results;
	int            registers_written;
	int            send_idle_pct;
	int            recv_idle_pct;

	// The predictor's own copy of the registers and of the per-pixel scan state.
	vpc_pkg::cfg_t live_cfg;
	int            band_pos;
	int            nir_level;
	int            red_level;
	int            prev_level;
	int            best_rise;
	bit            range_closed;
	int            pixel_pos;
	int            veg_total;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A run that hangs on a handshake is caught here; the normal run needs well under a tenth
	// of this time.
	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_pixel_state();
		band_pos     = 0;
		nir_level    = 0;
		red_level    = 0;
		prev_level   = 0;
		best_rise    = 0;
		range_closed = 1'b0;
	endfunction

	function automatic void restore_defaults();
		live_cfg            = '0;
		live_cfg.ndvi_limit = vpc_pkg::NDVI_LIMIT_RESET;
		live_cfg.test_mode  = vpc_pkg::TEST_MODE_RESET;
		clear_pixel_state();
		pixel_pos = 0;
		veg_total = 0;
	endfunction

	function automatic void load_register(logic [2:0] index, logic [16:0] data);
		case (index)
			vpc_pkg::REG_NIR_BAND:        live_cfg.nir_band        = data[7:0];
			vpc_pkg::REG_RED_BAND:        live_cfg.red_band        = data[7:0];
			vpc_pkg::REG_EDGE_FIRST_BAND: live_cfg.edge_first_band = data[7:0];
			vpc_pkg::REG_EDGE_LAST_BAND:  live_cfg.edge_last_band  = data[7:0];
			vpc_pkg::REG_NDVI_LIMIT:      live_cfg.ndvi_limit      = data[15:0];
			vpc_pkg::REG_EDGE_LIMIT:      live_cfg.edge_limit      = data[16:0];
			vpc_pkg::REG_TEST_MODE:       live_cfg.test_mode       = data[1:0];
			vpc_pkg::REG_REJECT_LABEL:    live_cfg.reject_label    = data[15:0];
			default: ;
		endcase
	endfunction

	// (n - r) / (n + r) in Q1.15, rounded to nearest with halves away from zero and held to
	// the signed 16-bit range. Both bands at zero give zero.
	function automatic int normalised_difference(int nir, int red);
		longint den;
		longint num;
		longint q;
		bit     neg;
		den = longint'(nir) + longint'(red);
		if (den <= 0)
			return 0;
		num = (longint'(nir) - longint'(red)) * 32768;
		neg = num < 0;
		if (neg)
			num = -num;
		q = (2 * num + den) / (2 * den);
		if (neg)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return int'(q);
	endfunction

	// Advances the scan state by one accepted band sample and, on the last band of a pixel,
	// works out the result that the block owes for it.
	function automatic void classify_band(input logic signed [15:0] value, input bit last,
			input bit soi, output bit produced, output pixel_result_t res);
		int s;
		int level;
		int rise;
		int step;
		int ratio;
		bit span_ok;
		bit veg;
		s        = value;
		span_ok  = live_cfg.edge_last_band > live_cfg.edge_first_band;
		produced = 1'b0;
		res      = '0;
		if (soi) begin
			pixel_pos = 0;
			veg_total = 0;
			clear_pixel_state();
		end
		// Bands past the supported count leave the scan state alone.
		if (band_pos < MAX_BANDS) begin
			level = (s < 0) ? 0 : s;
			if (band_pos == int'(live_cfg.nir_band))
				nir_level = level;
			if (band_pos == int'(live_cfg.red_band))
				red_level = level;
			if (span_ok && band_pos > int'(live_cfg.edge_first_band)
					&& band_pos <= int'(live_cfg.edge_last_band)) begin
				rise = s - prev_level;
				if (rise > 65535)
					rise = 65535;
				if (rise > best_rise)
					best_rise = rise;
			end
			if (span_ok && band_pos == int'(live_cfg.edge_last_band))
				range_closed = 1'b1;
			prev_level = s;
			band_pos++;
		end
		if (last) begin
			// A pixel that stops short of the end of the edge range reports a zero step.
			step  = range_closed ? best_rise : 0;
			ratio = normalised_difference(nir_level, red_level);
			veg   = 1'b1;
			if (live_cfg.test_mode[0] && ratio < int'(live_cfg.ndvi_limit))
				veg = 1'b0;
			if (veg && live_cfg.test_mode[1] && span_ok && step < int'(live_cfg.edge_limit))
				veg = 1'b0;
			if (veg && veg_total < MAX_PIXELS)
				veg_total++;
			res.pixel_index      = pixel_pos[19:0];
			res.ndvi             = ratio[15:0];
			res.veg_flag         = veg;
			res.mask_value       = veg ? vpc_pkg::VEG_MASK : live_cfg.reject_label;
			res.edge_step        = step[15:0];
			res.vegetation_count = veg_total[20:0];
			pixel_pos = (pixel_pos + 1) % MAX_PIXELS;
			clear_pixel_state();
			produced = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// Every result transfer is compared with the oldest expectation. The ready level for the
	// next cycle is drawn at the same edge, so the receiver stalls on any phase of the work.
	always @(posedge clk) begin : result_check
		pixel_result_t want;
		if (arst_n === 1'b1 && results_bus.valid === 1'b1 && results_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result transfer for pixel %0d with none expected",
					results_bus.pixel_index));
			end else begin
				want = pending_results.pop_front();
				check_field("pixel_index", results_bus.pixel_index, want.pixel_index);
				check_field("ndvi", results_bus.ndvi, want.ndvi);
				check_field("veg_flag", results_bus.veg_flag, want.veg_flag);
				check_field("mask_value", results_bus.mask_value, want.mask_value);
				check_field("edge_step", results_bus.edge_step, want.edge_step);
				check_field("vegetation_count", results_bus.vegetation_count,
					want.vegetation_count);
				results_checked++;
				if (want.veg_flag)
					veg_results++;
			end
		end
		results_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offers one band sample, after a random gap, and holds it until the block takes it.
	// The expectation is recorded at the accepting edge; a literal from the directed table
	// takes the place of the predicted result where one is given.
	task automatic push_sample(input logic signed [15:0] value, input bit last, input bit soi,
			input bit literal_ok, input pixel_result_t literal);
		bit            produced;
		pixel_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_bus.valid <= 1'b0;
			@(posedge clk);
		end
		samples_bus.valid          <= 1'b1;
		samples_bus.sample         <= value;
		samples_bus.last_band      <= last;
		samples_bus.start_of_image <= soi;
		@(posedge clk);
		while (samples_bus.ready !== 1'b1)
			@(posedge clk);
		classify_band(value, last, soi, produced, predicted);
		if (produced)
			pending_results = {pending_results, (literal_ok ? literal : predicted)};
		samples_in++;
	endtask

	// Stops offering samples and waits for every owed result, then lets the given number of
	// quiet cycles pass.
	task automatic quiesce(int settle);
		samples_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (settle)
			@(posedge clk);
	endtask

	// The write enable drops for a cycle between writes so that it is never lowered and
	// raised again in the same time step.
	task automatic write_reg(logic [2:0] index, int data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data[16:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		load_register(index, data[16:0]);
		registers_written++;
		@(posedge clk);
	endtask

	function automatic void row_reg(logic [2:0] index, int data);
		stim_row_t row;
		row           = '0;
		row.kind      = ROW_REG;
		row.reg_index = index;
		row.value     = data;
		directed_rows = {directed_rows, row};
	endfunction

	function automatic void row_sample(int value, bit last, bit soi);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_SAMPLE;
		row.value = value;
		row.last  = last;
		row.soi   = soi;
		directed_rows = {directed_rows, row};
	endfunction

	function automatic void row_checked(int value, bit soi, int index, int ndvi, bit veg,
			int mask, int step, int count);
		stim_row_t row;
		row                       = '0;
		row.kind                  = ROW_CHECKED;
		row.value                 = value;
		row.last                  = 1'b1;
		row.soi                   = soi;
		row.want.pixel_index      = index[19:0];
		row.want.ndvi             = ndvi[15:0];
		row.want.veg_flag         = veg;
		row.want.mask_value       = mask[15:0];
		row.want.edge_step        = step[15:0];
		row.want.vegetation_count = count[20:0];
		directed_rows = {directed_rows, row};
	endfunction

	// Mostly plausible reflectances, with full-range noise, values near zero and the extremes
	// mixed in so that clamping and large steps come up often.
	function automatic logic signed [15:0] draw_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 19))
			0, 1, 2: return r[15:0];
			3, 4:    return 16'($urandom_range(0, 100));
			5: begin
				case ($urandom_range(0, 4))
					0:       return -16'sd32768;
					1:       return -16'sd1;
					2:       return 16'sd0;
					3:       return 16'sd1;
					default: return 16'sd32767;
				endcase
			end
			default: return 16'($urandom_range(0, 32767));
		endcase
	endfunction

	// Writes all eight registers. The first random setting holds every register at its low end,
	// the last all but red and the first edge band at their high end; one setting in between
	// puts the bands near the top of the band range so that only long pixels reach them.
	task automatic random_config(int phase);
		int nir;
		int red;
		int first;
		int last;
		int ndvi_lim;
		int edge_lim;
		int mode;
		int label;
		if (phase == 0) begin
			nir      = 0;
			red      = 0;
			first    = 0;
			last     = 0;
			ndvi_lim = -32768;
			edge_lim = -65536;
			mode     = 0;
			label    = -32768;
		end else if (phase == 8) begin
			nir      = 255;
			red      = 253;
			first    = 250;
			last     = 255;
			ndvi_lim = 32767;
			edge_lim = 65535;
			mode     = 3;
			label    = 32767;
		end else begin
			if (phase == 4) begin
				nir   = $urandom_range(200, 255);
				red   = $urandom_range(200, 255);
				first = $urandom_range(240, 250);
				last  = $urandom_range(first + 1, 255);
			end else begin
				nir   = $urandom_range(0, 20);
				red   = $urandom_range(0, 20);
				first = $urandom_range(0, 18);
				// Now and then the edge range is left empty or reversed.
				last  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, first)
					: first + $urandom_range(1, 6);
			end
			ndvi_lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) - 32768
				: $urandom_range(0, 24000) - 8000;
			edge_lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) - 65536
				: $urandom_range(0, 6000) - 1500;
			mode     = $urandom_range(0, 3);
			label    = $urandom_range(0, 65535) - 32768;
		end
		write_reg(vpc_pkg::REG_NIR_BAND, nir);
		write_reg(vpc_pkg::REG_RED_BAND, red);
		write_reg(vpc_pkg::REG_EDGE_FIRST_BAND, first);
		write_reg(vpc_pkg::REG_EDGE_LAST_BAND, last);
		write_reg(vpc_pkg::REG_NDVI_LIMIT, ndvi_lim);
		write_reg(vpc_pkg::REG_EDGE_LIMIT, edge_lim);
		write_reg(vpc_pkg::REG_TEST_MODE, mode);
		write_reg(vpc_pkg::REG_REJECT_LABEL, label);
	endtask

	// Whole pixels of random length with random content. Most are short, some run past the
	// edge range, and where asked one runs past the supported band count. A start of image
	// now and then cuts a pixel short. The phase always ends on a last band.
	task automatic run_phase(int quota, bit long_pixels, bit hold_midway);
		int            sent;
		int            pixel_no;
		int            len;
		int            j;
		bit            soi;
		pixel_result_t none;
		sent     = 0;
		pixel_no = 0;
		none     = '0;
		while (sent < quota) begin
			if (long_pixels && pixel_no == 1)
				len = MAX_BANDS + $urandom_range(1, 6);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(25, 40);
			else
				len = $urandom_range(1, 18);
			// The sender holds back until every result owed so far has come out.
			if (hold_midway && pixel_no == 6)
				quiesce(0);
			for (j = 0; j < len; j++) begin
				soi = (j == 0 && pixel_no == 0 && $urandom_range(0, 1) == 1)
					|| $urandom_range(0, 79) == 0;
				push_sample(draw_sample(), j == len - 1, soi, 1'b0, none);
			end
			sent += len;
			pixel_no++;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		int        i;
		int        phase;
		stim_row_t row;

		clk                        = 1'b0;
		arst_n                     = 1'b0;
		cfg_we                     = 1'b0;
		cfg_index                  = '0;
		cfg_wdata                  = '0;
		samples_bus.valid          = 1'b0;
		samples_bus.sample         = '0;
		samples_bus.last_band      = 1'b0;
		samples_bus.start_of_image = 1'b0;
		results_bus.ready          = 1'b0;
		mismatches                 = 0;
		samples_in                 = 0;
		results_checked            = 0;
		veg_results                = 0;
		registers_written          = 0;
		send_idle_pct              = 30;
		recv_idle_pct              = 88;
		restore_defaults();

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: NIR and red both read band 0, so NDVI is zero, which misses the
		// default limit; the edge range is empty and the reject label is zero.
		row_checked(32767, 1'b0, 0, 0, 1'b0, 0, 0, 0);
		row_checked(-32768, 1'b0, 1, 0, 1'b0, 0, 0, 0);

		// NIR at band 2, red at band 1, edge range over bands 1 to 3, both tests enabled.
		row_reg(vpc_pkg::REG_NIR_BAND, 2);
		row_reg(vpc_pkg::REG_RED_BAND, 1);
		row_reg(vpc_pkg::REG_EDGE_FIRST_BAND, 1);
		row_reg(vpc_pkg::REG_EDGE_LAST_BAND, 3);
		row_reg(vpc_pkg::REG_NDVI_LIMIT, 0);
		row_reg(vpc_pkg::REG_EDGE_LIMIT, 100);
		row_reg(vpc_pkg::REG_TEST_MODE, 3);
		row_reg(vpc_pkg::REG_REJECT_LABEL, -32768);

		// Full-scale NIR over zero red: NDVI saturates at +1.
		row_sample(0, 1'b0, 1'b1);
		row_sample(0, 1'b0, 1'b0);
		row_sample(32767, 1'b0, 1'b0);
		row_checked(-1, 1'b0, 0, 32767, 1'b1, -1, 32767, 1);
		// Full-scale red over a negative NIR that clamps to zero: NDVI is -1.
		row_sample(0, 1'b0, 1'b0);
		row_sample(32767, 1'b0, 1'b0);
		row_sample(-5, 1'b0, 1'b0);
		row_checked(0, 1'b0, 1, -32768, 1'b0, -32768, 5, 1);
		// The widest possible step between neighbouring bands.
		row_sample(0, 1'b0, 1'b0);
		row_sample(-32768, 1'b0, 1'b0);
		row_sample(32767, 1'b0, 1'b0);
		row_checked(0, 1'b0, 2, 32767, 1'b1, -1, 65535, 2);
		// The pixel ends inside the edge range, so its step is zero and fails the edge test.
		row_sample(0, 1'b0, 1'b0);
		row_sample(0, 1'b0, 1'b0);
		row_checked(100, 1'b0, 3, 32767, 1'b0, -32768, 0, 2);
		// The pixel ends before the NIR and red bands: both read as zero.
		row_checked(50, 1'b0, 4, 0, 1'b0, -32768, 0, 2);
		// A start of image in the middle of a pixel drops the partial pixel and the counts.
		row_sample(5, 1'b0, 1'b0);
		row_sample(7, 1'b0, 1'b0);
		row_sample(0, 1'b0, 1'b1);
		row_sample(1000, 1'b0, 1'b0);
		row_sample(3000, 1'b0, 1'b0);
		row_checked(3000, 1'b0, 0, 16384, 1'b1, -1, 2000, 1);
		// With both tests off every pixel counts as vegetation.
		row_reg(vpc_pkg::REG_TEST_MODE, 0);
		row_checked(-1, 1'b1, 0, 0, 1'b1, -1, 0, 1);
		// Edge test alone over a reversed range: the test is skipped.
		row_reg(vpc_pkg::REG_EDGE_FIRST_BAND, 3);
		row_reg(vpc_pkg::REG_EDGE_LAST_BAND, 2);
		row_reg(vpc_pkg::REG_TEST_MODE, 2);
		row_sample(40, 1'b1, 1'b0);

		for (i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			case (row.kind)
				ROW_REG: begin
					if (i == 0 || directed_rows[i - 1].kind != ROW_REG)
						quiesce(SETTLE_CYCLES);
					write_reg(row.reg_index, row.value);
				end
				ROW_SAMPLE: push_sample(row.value[15:0], row.last, row.soi, 1'b0, row.want);
				default:    push_sample(row.value[15:0], 1'b1, row.soi, 1'b1, row.want);
			endcase
		end

		// Nine random settings: three with a slow receiver, three with a slow sender and
		// three with neither side idling.
		for (phase = 0; phase < 9; phase++) begin
			case (phase / 3)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			quiesce(SETTLE_CYCLES);
			random_config(phase);
			run_phase(PHASE_ITEMS, phase == 4 || phase == 8, phase == 4);
		end

		quiesce(SETTLE_CYCLES);

		$display("Covered %0d band samples, %0d pixel results (%0d vegetation) and %0d writes.",
			samples_in, results_checked, veg_results, registers_written);
		$display("Reset defaults, directed corner pixels and nine random settings; %0d mismatches.",
			mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
